@@ rtl/stick_deadzone_conditioner_assert.svh @@
// assertion macros for the stick dead zone conditioner checker
// users supply clk_i and rst_ni in the scope that expands them
`ifndef STICK_DEADZONE_CONDITIONER_ASSERT_SVH
`define STICK_DEADZONE_CONDITIONER_ASSERT_SVH

// property checked outside reset
`define SDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that also looks at the reset itself
`define SDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/sdc_pkg.sv @@
// shared types and constants for the stick dead zone conditioner
// used by every rtl file of the block but the checker, depends on nothing
`default_nettype none

package sdc_pkg;

  // fixed point, 16 fraction bits
  localparam int unsigned Q_ONE         = 65536;
  localparam int unsigned SQRT2_Q16     = 92682;
  localparam int unsigned CARD_GAIN_Q16 = 158218;
  localparam int unsigned DEFAULT_RANGE = 127;
  localparam int unsigned PLAYER_LIMIT  = 6;

  // item queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // shared divider widths
  localparam int unsigned NUM_W = 48;
  localparam int unsigned DEN_W = 24;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE       = 2'd0,
    CFG_PSX_RANGE      = 2'd1,
    CFG_CAPTURE_ENABLE = 2'd2,
    CFG_PLAYER_NUMBER  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0] deadzone;
    logic       psx_range;
    logic       capture_enable;
    logic [2:0] player_number;
  } cfg_t;

  // one classified axis update
  typedef struct packed {
    logic              stick;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic [7:0]        ax;
    logic [7:0]        ay;
    logic [7:0]        mx;
    logic [15:0]       ss;
    logic              diag;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/sdc_div.sv @@
// shared restoring divider, one quotient bit a cycle, rounds half to even
// depends on sdc_pkg
`default_nettype none

module sdc_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [sdc_pkg::NUM_W-1:0] num_i,
  input  wire logic [sdc_pkg::DEN_W-1:0] den_i,
  output logic                          done_o,
  output logic [sdc_pkg::NUM_W-1:0]     quo_o
);

  localparam int unsigned CNT_W = $clog2(sdc_pkg::NUM_W + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND} dstate_e;

  dstate_e                   state_q;
  logic [sdc_pkg::NUM_W-1:0] work_q;
  logic [sdc_pkg::DEN_W-1:0] rem_q;
  logic [sdc_pkg::DEN_W-1:0] den_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [sdc_pkg::NUM_W-1:0] quo_q;
  logic                      done_q;

  logic [sdc_pkg::DEN_W:0]   rem_sh;
  logic                      ge;
  logic [sdc_pkg::DEN_W:0]   rem_n;
  logic [sdc_pkg::DEN_W:0]   twice;
  logic                      rnd_up;

  always_comb begin
    rem_sh = {rem_q, work_q[sdc_pkg::NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_n  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
    twice  = {rem_q, 1'b0};
    rnd_up = (twice > {1'b0, den_q}) || ((twice == {1'b0, den_q}) && work_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      work_q  <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      cnt_q   <= '0;
      quo_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            work_q  <= num_i;
            den_q   <= den_i;
            rem_q   <= '0;
            cnt_q   <= CNT_W'(sdc_pkg::NUM_W);
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q  <= rem_n[sdc_pkg::DEN_W-1:0];
          work_q <= {work_q[sdc_pkg::NUM_W-2:0], ge};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= D_ROUND;
          end
        end
        D_ROUND: begin
          // divide by zero gives zero
          if (den_q == '0) begin
            quo_q <= '0;
          end else begin
            quo_q <= work_q + sdc_pkg::NUM_W'(rnd_up);
          end
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ rtl/sdc_front.sv @@
// front part: takes axis updates, keeps stick positions, classifies items
// depends on sdc_pkg
`default_nettype none

module sdc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sdc_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              stick_id_i,
  input  wire logic              axis_id_i,
  input  wire logic signed [7:0] offset_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output sdc_pkg::item_t         item_o
);

  logic signed [7:0] lx_q, ly_q, rx_q, ry_q;
  logic signed [7:0] cx, cy, nx, ny;
  logic              enabled, accept;
  logic [8:0]        wx, wy;
  logic [7:0]        ax, ay, mx, mn;
  logic [12:0]       mn20, mx17;

  always_comb begin
    enabled = cfg_i.capture_enable && (cfg_i.player_number != 3'd0) &&
              (32'(cfg_i.player_number) <= sdc_pkg::PLAYER_LIMIT);
    accept  = in_valid_i && !q_full_i;
    cx = stick_id_i ? rx_q : lx_q;
    cy = stick_id_i ? ry_q : ly_q;
    nx = axis_id_i ? cx : offset_i;
    ny = axis_id_i ? offset_i : cy;
    wx = nx[7] ? 9'(-$signed({nx[7], nx})) : {1'b0, nx};
    wy = ny[7] ? 9'(-$signed({ny[7], ny})) : {1'b0, ny};
    ax = wx[7:0];
    ay = wy[7:0];
    mx = (ax > ay) ? ax : ay;
    mn = (ax > ay) ? ay : ax;
    mn20 = 13'(mn) * 13'd20;
    mx17 = 13'(mx) * 13'd17;
    item_o.stick = stick_id_i;
    item_o.x     = nx;
    item_o.y     = ny;
    item_o.ax    = ax;
    item_o.ay    = ay;
    item_o.mx    = mx;
    item_o.ss    = 16'(ax) * 16'(ax) + 16'(ay) * 16'(ay);
    item_o.diag  = (mn != 8'd0) && (mn20 >= mx17);
  end

  assign in_stall_o = q_full_i;
  assign push_o     = accept && enabled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0;
      ly_q <= '0;
      rx_q <= '0;
      ry_q <= '0;
    end else if (push_o) begin
      if (stick_id_i) begin
        rx_q <= nx;
        ry_q <= ny;
      end else begin
        lx_q <= nx;
        ly_q <= ny;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/sdc_queue.sv @@
// short item queue between the front and the back
// depends on sdc_pkg
`default_nettype none

module sdc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sdc_pkg::item_t item_i,
  input  wire logic           pop_i,
  output logic                valid_o,
  output logic                full_o,
  output sdc_pkg::item_t      item_o
);

  localparam int unsigned PTR_W = $clog2(sdc_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sdc_pkg::QUEUE_DEPTH + 1);

  sdc_pkg::item_t   mem_q [sdc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CNT_W'(sdc_pkg::QUEUE_DEPTH);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/sdc_back.sv @@
// back part: learns peaks and runs the radial dead zone arithmetic
// depends on sdc_pkg and sdc_div
`default_nettype none

module sdc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sdc_pkg::cfg_t  cfg_i,
  input  wire logic           q_valid_i,
  input  wire sdc_pkg::item_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                out_stick_o,
  output logic signed [7:0]   out_x_o,
  output logic signed [7:0]   out_y_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQRT, S_PEAK, S_BOX, S_CARD_MUL, S_CARD, S_MD_MUL, S_MC_MUL,
    S_RANGE, S_SC_MUL, S_SC_START, S_SC_WAIT, S_CAP_MUL, S_ADJ,
    S_X_MUL, S_X_START, S_X_WAIT, S_Y_MUL, S_Y_START, S_Y_WAIT, S_OUT
  } state_e;

  state_e            state_q;
  sdc_pkg::item_t    it_q;
  logic [47:0]       rest_q, res_q, bit_q;
  logic [23:0]       r_q;
  logic [16:0]       box_q, card_q;
  logic [7:0]        mc_q;
  logic [23:0]       md_q, range_q, wr_q, adj_q;
  logic [47:0]       t_q;
  logic [7:0]        ox_q;
  logic [47:0]       prod_q;
  logic signed [7:0] rx_q, ry_q;
  logic              out_valid_q, out_stick_q;
  logic signed [7:0] out_x_q, out_y_q;
  logic [15:0]       pds_q [2];
  logic [23:0]       pdr_q [2];
  logic [7:0]        pc_q  [2];

  logic [6:0]        dz;
  logic [13:0]       dz_sq;
  logic [7:0]        dz2;
  logic [47:0]       sq_sum;
  logic [23:0]       mul_a, mul_b;
  logic              div_start, div_done;
  logic [47:0]       div_num, div_quo;
  logic [23:0]       div_den;
  logic [16:0]       diff;
  logic [31:0]       rnd;
  logic [47:0]       rsum;
  logic [24:0]       range_w;
  logic [24:0]       cap_w;
  logic [24:0]       adj_w;
  logic [7:0]        oy_w;
  logic              big_path;

  function automatic logic [31:0] round_q16(input logic [47:0] p);
    logic [31:0] q;
    q = p[47:16];
    if ((p[15:0] > 16'h8000) || ((p[15:0] == 16'h8000) && q[0])) q = q + 32'd1;
    return q;
  endfunction

  function automatic logic signed [7:0] clamp_out(input logic neg, input logic [7:0] mag,
                                                  input logic psx);
    logic signed [9:0] v;
    logic signed [9:0] lo;
    v  = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    lo = psx ? -10'sd128 : -10'sd127;
    if (v < lo) v = lo;
    else if (v > 10'sd127) v = 10'sd127;
    return v[7:0];
  endfunction

  always_comb begin
    dz       = cfg_i.deadzone;
    dz_sq    = 14'(dz) * 14'(dz);
    dz2      = {dz, 1'b0};
    sq_sum   = res_q + bit_q;
    diff     = (17'(sdc_pkg::SQRT2_Q16) > box_q) ? 17'(sdc_pkg::SQRT2_Q16) - box_q : '0;
    rnd      = round_q16(prod_q);
    // blend summed at full precision, rounded once
    rsum     = t_q + {prod_q[31:0], 16'h0000};
    range_w  = 25'(round_q16(rsum));
    cap_w    = prod_q[24:0];
    adj_w    = (25'(wr_q) < cap_w) ? 25'(wr_q) : cap_w;
    oy_w     = (div_quo[47:8] != '0) ? 8'hFF : div_quo[7:0];
    big_path = (dz > 7'd2) && (it_q.ss > 16'(dz_sq));

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_CARD_MUL: begin mul_a = 24'(diff);                    mul_b = 24'(sdc_pkg::CARD_GAIN_Q16); end
      S_MD_MUL:   begin mul_a = 24'(17'(sdc_pkg::Q_ONE) - card_q); mul_b = md_q;               end
      S_MC_MUL:   begin mul_a = 24'(card_q);                  mul_b = 24'(mc_q);                   end
      S_SC_MUL:   begin mul_a = range_q - r_q;                mul_b = range_q;                     end
      S_CAP_MUL:  begin mul_a = 24'(box_q);                   mul_b = 24'(mc_q);                   end
      S_X_MUL:    begin mul_a = adj_q;                        mul_b = 24'(it_q.ax);                end
      S_Y_MUL:    begin mul_a = adj_q;                        mul_b = 24'(it_q.ay);                end
      default:    begin mul_a = '0;                           mul_b = '0;                          end
    endcase

    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      S_PEAK: begin
        div_start = big_path;
        div_num   = 48'(r_q);
        div_den   = 24'(it_q.mx);
      end
      S_SC_START: begin
        div_start = 1'b1;
        div_num   = prod_q;
        div_den   = (range_q > {1'b0, dz, 16'h0000}) ? range_q - {1'b0, dz, 16'h0000} : '0;
      end
      S_X_START, S_Y_START: begin
        div_start = 1'b1;
        div_num   = prod_q;
        div_den   = r_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  sdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // single multiplier, registered
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      it_q        <= '0;
      rest_q      <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      r_q         <= '0;
      box_q       <= '0;
      card_q      <= '0;
      mc_q        <= '0;
      md_q        <= '0;
      t_q         <= '0;
      range_q     <= '0;
      wr_q        <= '0;
      adj_q       <= '0;
      ox_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      out_valid_q <= 1'b0;
      out_stick_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      pds_q[0]    <= '0;
      pds_q[1]    <= '0;
      pdr_q[0]    <= '0;
      pdr_q[1]    <= '0;
      pc_q[0]     <= '0;
      pc_q[1]     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            it_q    <= q_item_i;
            rest_q  <= {q_item_i.ss, 32'h0};
            res_q   <= '0;
            bit_q   <= 48'h1 << 46;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          // each step consumes two radicand bits and settles a result bit
          if (bit_q != '0) begin
            if (rest_q >= sq_sum) begin
              rest_q <= rest_q - sq_sum;
              res_q  <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end else begin
            r_q     <= res_q[23:0] + 24'(rest_q > res_q);
            state_q <= S_PEAK;
          end
        end
        S_PEAK: begin
          if (it_q.diag && (it_q.ss > pds_q[it_q.stick])) begin
            pds_q[it_q.stick] <= it_q.ss;
            pdr_q[it_q.stick] <= r_q;
          end
          if (it_q.mx > pc_q[it_q.stick]) pc_q[it_q.stick] <= it_q.mx;
          if (dz <= 7'd2) begin
            if ((dz != 7'd0) && (8'(dz) >= it_q.mx)) begin
              rx_q <= '0;
              ry_q <= '0;
            end else begin
              rx_q <= it_q.x;
              ry_q <= it_q.y;
            end
            state_q <= S_OUT;
          end else if (!big_path) begin
            rx_q    <= '0;
            ry_q    <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_BOX;
          end
        end
        S_BOX: begin
          if (div_done) begin
            box_q   <= div_quo[16:0];
            mc_q    <= (pc_q[it_q.stick] > dz2) ? pc_q[it_q.stick]
                                                : 8'(sdc_pkg::DEFAULT_RANGE);
            md_q    <= (pdr_q[it_q.stick] > {dz2, 16'h0000}) ? pdr_q[it_q.stick]
                                                : {8'(sdc_pkg::DEFAULT_RANGE), 16'h0000};
            state_q <= S_CARD_MUL;
          end
        end
        S_CARD_MUL: state_q <= S_CARD;
        S_CARD: begin
          card_q  <= (rnd > sdc_pkg::Q_ONE) ? 17'(sdc_pkg::Q_ONE) : rnd[16:0];
          state_q <= S_MD_MUL;
        end
        S_MD_MUL: state_q <= S_MC_MUL;
        S_MC_MUL: begin
          // keep the diagonal share unrounded
          t_q     <= prod_q;
          state_q <= S_RANGE;
        end
        S_RANGE: begin
          range_q <= range_w[23:0];
          if (range_w[23:0] > r_q) begin
            state_q <= S_SC_MUL;
          end else begin
            wr_q    <= range_w[23:0];
            state_q <= S_CAP_MUL;
          end
        end
        S_SC_MUL:   state_q <= S_SC_START;
        S_SC_START: state_q <= S_SC_WAIT;
        S_SC_WAIT: begin
          if (div_done) begin
            wr_q    <= (div_quo < 48'(range_q)) ? range_q - div_quo[23:0] : '0;
            state_q <= S_CAP_MUL;
          end
        end
        S_CAP_MUL: state_q <= S_ADJ;
        S_ADJ: begin
          // scaled radius above the input radius: raw position passes
          if (adj_w > 25'(r_q)) begin
            rx_q    <= it_q.x;
            ry_q    <= it_q.y;
            state_q <= S_OUT;
          end else begin
            adj_q   <= adj_w[23:0];
            state_q <= S_X_MUL;
          end
        end
        S_X_MUL:   state_q <= S_X_START;
        S_X_START: state_q <= S_X_WAIT;
        S_X_WAIT: begin
          if (div_done) begin
            ox_q    <= oy_w;
            state_q <= S_Y_MUL;
          end
        end
        S_Y_MUL:   state_q <= S_Y_START;
        S_Y_START: state_q <= S_Y_WAIT;
        S_Y_WAIT: begin
          if (div_done) begin
            rx_q    <= clamp_out(it_q.x[7], ox_q, cfg_i.psx_range);
            ry_q    <= clamp_out(it_q.y[7], oy_w, cfg_i.psx_range);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_stick_q <= it_q.stick;
            out_x_q     <= rx_q;
            out_y_q     <= ry_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_stick_o = out_stick_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;

endmodule

`default_nettype wire

@@ rtl/stick_deadzone_conditioner.sv @@
// per item: the square root always runs; a dead zone of 2 or less or a position inside the zone
// then goes to the output, else the full radial rescale runs (up to four divides on the shared divider)
// the back side takes a new item only after handing the last one to its output register
// a two-entry queue lets the input side keep taking items while the back side works
// reset: asynchronous active low, clears config, stick positions, peaks and all handshakes
// depends on sdc_pkg, sdc_front, sdc_queue, sdc_back
`default_nettype none

module stick_deadzone_conditioner (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sdc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // axis update input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          stick_id_i,
  input  wire logic                          axis_id_i,
  input  wire logic signed [7:0]             offset_i,
  // conditioned position output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               out_stick_o,
  output logic signed [7:0]                  out_x_o,
  output logic signed [7:0]                  out_y_o
);

  sdc_pkg::cfg_t  cfg_q;
  logic           q_push, q_pop, q_valid, q_full;
  sdc_pkg::item_t push_item, pop_item;

  // registers are always writable; a transfer happens when valid is high
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sdc_pkg::cfg_idx_e'(cfg_index_i))
        sdc_pkg::CFG_DEADZONE:       cfg_q.deadzone       <= cfg_data_i[6:0];
        sdc_pkg::CFG_PSX_RANGE:      cfg_q.psx_range      <= cfg_data_i[0];
        sdc_pkg::CFG_CAPTURE_ENABLE: cfg_q.capture_enable <= cfg_data_i[0];
        sdc_pkg::CFG_PLAYER_NUMBER:  cfg_q.player_number  <= cfg_data_i[2:0];
        default:                     cfg_q                <= cfg_q;
      endcase
    end
  end

  // front: position update and classification, drops items when not grabbed
  sdc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stick_id_i (stick_id_i),
    .axis_id_i  (axis_id_i),
    .offset_i   (offset_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .item_o     (push_item)
  );

  // every queued item produces exactly one result
  sdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .item_o  (pop_item)
  );

  // back: sqrt, peak learning, dead zone rescale, output register
  sdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_stick_o (out_stick_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o)
  );

endmodule

`default_nettype wire

@@ rtl/sdc_checker.sv @@
// port level checks for the stick dead zone conditioner, bound to the top level
// depends on stick_deadzone_conditioner_assert.svh
`default_nettype none
`include "stick_deadzone_conditioner_assert.svh"

module sdc_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              out_stick_o,
  input wire logic signed [7:0] out_x_o,
  input wire logic signed [7:0] out_y_o
);

  `SDC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `SDC_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_x_o) && $stable(out_y_o) && $stable(out_stick_o), "stalled result changed")
  `SDC_ASSERT_RST(a_cfg_ready, rst_ni |-> cfg_ready_o, "config port refused a write")
  `SDC_ASSERT_RST(a_reset_quiet, $rose(rst_ni) |-> !out_valid_o, "result shown right out of reset")

endmodule

bind stick_deadzone_conditioner sdc_checker u_sdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_stick_o (out_stick_o),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o)
);

`default_nettype wire

@@ sim/stick_deadzone_conditioner_tb.sv @@
// self-checking testbench for stick_deadzone_conditioner: directed and random axis updates
// against an in-bench fixed point predictor, with random idling on both channels
// depends on sdc_pkg and the stick_deadzone_conditioner rtl
`timescale 1ns / 1ps

module stick_deadzone_conditioner_tb;
  import sdc_pkg::*;

  // one axis update waiting for the driver
  typedef struct {
    logic             stick;
    logic             axis;
    logic signed [7:0] offset;
  } axis_upd_t;

  // one conditioned position
  typedef struct {
    logic             stick;
    logic signed [7:0] x;
    logic signed [7:0] y;
  } cond_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  cfg_ready;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             stick_id = 1'b0;
  logic             axis_id = 1'b0;
  logic signed [7:0] offset = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_stick;
  logic signed [7:0] out_x;
  logic signed [7:0] out_y;

  stick_deadzone_conditioner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .stick_id_i  (stick_id),
    .axis_id_i   (axis_id),
    .offset_i    (offset),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_stick_o (out_stick),
    .out_x_o     (out_x),
    .out_y_o     (out_y)
  );

  always #10 clk_i = ~clk_i;

  // pending updates and expected positions
  axis_upd_t pending_upd[$];
  cond_pos_t expected_pos[$];

  // idling percentages, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned err_count = 0;
  int unsigned upd_count = 0;
  int unsigned pos_count = 0;

  // shadow configuration
  logic [6:0] sh_deadzone = '0;
  logic       sh_wide_low = 1'b0;
  logic       sh_capture = 1'b0;
  logic [2:0] sh_player = '0;

  // shadow per-stick state
  logic signed [7:0] sh_axis_pos [4];
  logic [15:0]       sh_diag_sq [2];
  logic [23:0]       sh_diag_rad [2];
  logic [7:0]        sh_card_peak [2];

  initial begin
    for (int i = 0; i < 4; i++) sh_axis_pos[i] = '0;
    for (int i = 0; i < 2; i++) begin
      sh_diag_sq[i] = '0;
      sh_diag_rad[i] = '0;
      sh_card_peak[i] = '0;
    end
  end

  // quotient rounded to nearest, ties to even
  function automatic longint unsigned div_round_even(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned twice;
    if (d == 0) return 0;
    q = n / d;
    twice = (n % d) * 2;
    if (twice > d || (twice == d && q[0])) q++;
    return q;
  endfunction

  // integer square root rounded to nearest
  function automatic longint unsigned isqrt_round(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rest;
    res = 0;
    bitv = 64'd1 << 62;
    rest = n;
    while (bitv > rest) bitv >>= 2;
    while (bitv != 0) begin
      if (rest >= res + bitv) begin
        rest -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (n - res * res > res) res++;
    return res;
  endfunction

  function automatic int clamp_axis(int v);
    int lo;
    lo = sh_wide_low ? -128 : -127;
    if (v < lo) return lo;
    if (v > 127) return 127;
    return v;
  endfunction

  // radial dead zone and rescale of one stick position
  function automatic void apply_deadzone(inout int x, inout int y, input int s);
    longint unsigned ax, ay, m, ss, r, box, diff, card, mc, md, rng, wr, cap, adj, ox, oy;
    longint unsigned dz, den, sc;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    dz = sh_deadzone;
    if (dz <= 2) begin
      if (dz != 0 && m <= dz) begin
        x = 0;
        y = 0;
      end
      return;
    end
    ss = ax * ax + ay * ay;
    if (ss <= dz * dz) begin
      x = 0;
      y = 0;
      return;
    end
    r = isqrt_round(ss << 32);
    box = div_round_even(r, m);
    diff = (SQRT2_Q16 > box) ? SQRT2_Q16 - box : 0;
    card = div_round_even(diff * CARD_GAIN_Q16, Q_ONE);
    if (card > Q_ONE) card = Q_ONE;
    mc = (sh_card_peak[s] > 2 * dz) ? (longint'(sh_card_peak[s]) << 16)
                                    : (longint'(DEFAULT_RANGE) << 16);
    md = (sh_diag_rad[s] > ((2 * dz) << 16)) ? longint'(sh_diag_rad[s])
                                             : (longint'(DEFAULT_RANGE) << 16);
    rng = div_round_even(card * mc + (Q_ONE - card) * md, Q_ONE);
    wr = rng;
    if (rng > r) begin
      den = (rng > (dz << 16)) ? rng - (dz << 16) : 0;
      sc = div_round_even((rng - r) * rng, den);
      wr = (sc < rng) ? rng - sc : 0;
    end
    cap = div_round_even(mc * box, Q_ONE);
    adj = (wr < cap) ? wr : cap;
    // never grow the radius
    if (adj > r) return;
    ox = div_round_even(adj * ax, r);
    oy = div_round_even(adj * ay, r);
    if (ox > 255) ox = 255;
    if (oy > 255) oy = 255;
    x = clamp_axis((x < 0) ? -int'(ox) : int'(ox));
    y = clamp_axis((y < 0) ? -int'(oy) : int'(oy));
  endfunction

  // update the shadow state for one accepted transfer, queue its position if any
  function automatic void predict_update(axis_upd_t u);
    int s, x, y;
    longint unsigned ax, ay, mx, mn, ss;
    cond_pos_t p;
    if (!sh_capture || sh_player == 0 || sh_player > PLAYER_LIMIT) return;
    s = u.stick;
    sh_axis_pos[s * 2 + u.axis] = u.offset;
    x = sh_axis_pos[s * 2];
    y = sh_axis_pos[s * 2 + 1];
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    mx = (ax > ay) ? ax : ay;
    mn = (ax > ay) ? ay : ax;
    // near diagonal learns the peak radius
    if (mn != 0 && 20 * mn >= 17 * mx) begin
      ss = ax * ax + ay * ay;
      if (ss > sh_diag_sq[s]) begin
        sh_diag_sq[s] = ss[15:0];
        sh_diag_rad[s] = isqrt_round(ss << 32);
      end
    end
    if (mx > sh_card_peak[s]) sh_card_peak[s] = mx[7:0];
    apply_deadzone(x, y, s);
    p.stick = u.stick;
    p.x = x[7:0];
    p.y = y[7:0];
    expected_pos.push_back(p);
  endfunction

  // driver: presents pending updates, predicts at each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    axis_upd_t u;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else begin
        if (in_valid) begin
          u.stick = stick_id;
          u.axis = axis_id;
          u.offset = offset;
          predict_update(u);
          upd_count++;
        end
        if (pending_upd.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          u = pending_upd.pop_front();
          in_valid <= 1'b1;
          stick_id <= u.stick;
          axis_id <= u.axis;
          offset <= u.offset;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, compares every accepted result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    cond_pos_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        pos_count++;
        if (expected_pos.size() == 0) begin
          $error("unexpected result: stick %0d x %0d y %0d", out_stick, out_x, out_y);
          err_count++;
        end else begin
          e = expected_pos.pop_front();
          if (out_stick !== e.stick) begin
            $error("out_stick: expected %0d actual %0d", e.stick, out_stick);
            err_count++;
          end
          if (out_x !== e.x) begin
            $error("out_x: expected %0d actual %0d", e.x, out_x);
            err_count++;
          end
          if (out_y !== e.y) begin
            $error("out_y: expected %0d actual %0d", e.y, out_y);
            err_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one register write transfer; to be used only while the block is idle, which the task does not check
  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DEADZONE:       sh_deadzone = val[6:0];
      CFG_PSX_RANGE:      sh_wide_low = val[0];
      CFG_CAPTURE_ENABLE: sh_capture = val[0];
      CFG_PLAYER_NUMBER:  sh_player = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned dz, int unsigned wide, int unsigned cap,
                            int unsigned plr);
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_PSX_RANGE, wide);
    write_reg(CFG_CAPTURE_ENABLE, cap);
    write_reg(CFG_PLAYER_NUMBER, plr);
  endtask

  // wait for all transfers and results, then the worst-case latency for silent updates
  task automatic drain();
    while (pending_upd.size() != 0 || in_valid || expected_pos.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic void push_upd(int s, int a, int v);
    axis_upd_t u;
    u.stick = s[0];
    u.axis = a[0];
    u.offset = v[7:0];
    pending_upd.push_back(u);
  endfunction

  function automatic void push_pos(int s, int x, int y);
    push_upd(s, 0, x);
    push_upd(s, 1, y);
  endfunction

  // one stick move with random content, mostly well formed x then y pairs
  function automatic void push_random_move();
    int s, a, b, kind;
    s = $urandom_range(1);
    kind = $urandom_range(9);
    a = $urandom_range(127, 1);
    if (kind < 4) begin
      // near diagonal, ratio above the learning threshold
      b = a - $urandom_range(a / 7);
      if ($urandom_range(1)) push_pos(s, $urandom_range(1) ? -a : a, $urandom_range(1) ? -b : b);
      else push_pos(s, $urandom_range(1) ? -b : b, $urandom_range(1) ? -a : a);
    end else if (kind < 6) begin
      // near cardinal
      b = $urandom_range(a / 4);
      push_pos(s, $urandom_range(1) ? -a : a, $urandom_range(1) ? -b : b);
    end else if (kind < 8) begin
      // small moves around the dead zone
      push_pos(s, $urandom_range(12) - 6, $urandom_range(12) - 6);
    end else begin
      // single axis noise over the full range
      push_upd(s, $urandom_range(1), $urandom_range(255) - 128);
    end
  endfunction

  // idling mode by phase: none, sender, receiver, both
  function automatic void set_idling(int mode);
    send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 21 : 79) : 0;
    recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 21 : 79) : 0;
  endfunction

  initial begin
    int dz_pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no dead zone, field extremes, both sticks and axes
    set_idling(0);
    set_config(0, 0, 1, 1);
    push_pos(0, 127, -128);
    push_pos(1, -128, 127);
    push_pos(0, 0, 0);
    drain();

    // small dead zone zeroes small cardinal distances
    set_config(2, 0, 1, 6);
    push_pos(0, 2, -2);
    push_pos(1, 3, 0);
    push_pos(1, -1, 1);
    drain();

    // large dead zone with the wide low end: inside zone, diagonal, cardinal, clamp
    set_config(10, 1, 1, 3);
    push_pos(0, 5, 5);
    push_pos(0, 90, 90);
    push_pos(0, 127, 0);
    push_pos(1, -128, -128);
    push_pos(1, -128, 3);
    drain();

    // silent updates: capture off, player unassigned, player out of range; then a full scale dead zone
    set_config(127, 0, 0, 1);
    push_pos(0, 50, 50);
    drain();
    set_config(127, 0, 1, 0);
    push_pos(1, 60, -60);
    drain();
    set_config(127, 0, 1, 7);
    push_pos(1, -70, 70);
    drain();
    set_config(127, 0, 1, 2);
    push_pos(0, 127, 127);
    drain();

    // random phases over varied settings and idling
    for (int ph = 0; ph < 16; ph++) begin
      set_idling(ph % 4);
      dz_pick = $urandom_range(5);
      set_config((dz_pick == 0) ? 0 : (dz_pick == 1) ? $urandom_range(2, 1) :
                 (dz_pick == 2) ? 127 : $urandom_range(40, 3),
                 $urandom_range(1), ($urandom_range(7) != 0),
                 ($urandom_range(9) == 0) ? 7 * $urandom_range(1) : $urandom_range(6, 1));
      for (int k = 0; k < 24; k++) push_random_move();
      drain();
    end

    $display("%0d axis updates accepted, %0d conditioned positions checked", upd_count,
             pos_count);
    $display("dead zones from none to full scale, both low limits, gated capture and players");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // timeout
  initial begin
    #400_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
